// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock with an active-low reset.
`define DVRT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must hold its value while a condition holds.
`define DVRT_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

// ----- rtl/dvrt_pkg.sv -----
// Shared types and constants of the route table.
// No dependencies.
`timescale 1ns / 1ps
package dvrt_pkg;

  localparam int unsigned ID_W   = 6;
  localparam int unsigned IDS    = 64;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned INCOST_W = 16;
  localparam int unsigned TICK_W = 20;
  localparam int unsigned CFG_ADDR_W = 1;

  localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
  localparam logic [OP_W-1:0] OP_WAKE   = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd3;

  localparam logic [CFG_ADDR_W-1:0] CFG_SELF_ID  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSRC,
    S_RDST,
    S_CMP,
    S_WALK,
    S_WCHK,
    S_WR,
    S_FIN,
    S_OUT
  } state_e;

endpackage

// ----- rtl/distance_vector_route_table.sv -----
// Route table top level: storage, walk sequencer and handshakes.
// Depends on dvrt_pkg.
//
//  channel | signals                              | direction
//  in      | in_valid_i / in_stall_o + fields     | item in
//  out     | out_valid_o / out_stall_i + fields   | result out
//  cfg     | cfg_we_i, cfg_addr_i, cfg_wdata_i    | register write
//
// Init steps through RDST, CMP, FIN and OUT; wake, tick and read through FIN
// and OUT; update through RSRC, RDST, CMP, WALK/WCHK per entry visited on the
// next-hop walk (at most NODES), WR on success, FIN, OUT; one table read port.
// Reset clears valid and neighbour bits at once; no clearing pass is needed.
// A result waits in the output register; a new transaction is taken meanwhile,
// but the sequencer holds in its last step while the output is stalled.
`timescale 1ns / 1ps
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int unsigned NODES     = 64,
  parameter int unsigned COST_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [TICK_W-1:0]     cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [ID_W-1:0]       src_id_i,
  input  logic [ID_W-1:0]       dest_id_i,
  input  logic [INCOST_W-1:0]   cost_i,
  input  logic [ID_W-1:0]       next_hop_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  entry_valid_o,
  output logic [INCOST_W-1:0]   entry_cost_o,
  output logic [ID_W-1:0]       entry_next_hop_o,
  output logic                  is_neighbor_o,
  output logic                  changed_o,
  output logic                  send_update_o,
  output logic                  walk_failed_o
);

  localparam int unsigned TBL  = (NODES < IDS) ? NODES : IDS;
  localparam int unsigned IW   = (TBL > 1) ? $clog2(TBL) : 1;
  localparam int unsigned SW   = $clog2(NODES + 1);
  localparam int unsigned MW   = COST_BITS + ID_W;
  localparam logic [COST_BITS:0] COST_MAX = {1'b0, {COST_BITS{1'b1}}};

  // configuration
  logic [ID_W-1:0]   self_q;
  logic [TICK_W-1:0] intv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q <= '0;
      intv_q <= TICK_W'(100);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SELF_ID:  self_q <= cfg_wdata_i[ID_W-1:0];
        CFG_INTERVAL: intv_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  // latched transaction
  logic [OP_W-1:0]      op_q;
  logic [ID_W-1:0]      src_q, dest_q, nh_q;
  logic                 last_q;
  logic [COST_BITS-1:0] sum_q, sum_d;
  logic                 src_ok_q, src_ok_d;
  logic [ID_W-1:0]      walk_q, walk_d;
  logic [SW-1:0]        steps_q, steps_d;
  logic                 chg_q, chg_d, fail_q, fail_d, send_q, send_d;
  logic                 awake_q, awake_d, msg_q, msg_d;
  logic [TICK_W-1:0]    tick_q, tick_d;

  // table storage
  logic [MW-1:0]  mem [TBL];
  logic [MW-1:0]  rd_q;
  logic [IW-1:0]  rd_addr, wr_addr;
  logic [MW-1:0]  wr_data;
  logic           wr_en;
  logic [TBL-1:0] valid_q, nbr_q;
  logic           nbr_set;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // probed entry: which id the read data belongs to in this state
  logic [ID_W-1:0]      probe_id;
  logic                 probe_in, probe_hr;
  logic [COST_BITS-1:0] probe_cost;
  logic [ID_W-1:0]      probe_next;

  always_comb begin
    case (state_q)
      S_RDST:  probe_id = src_q;
      S_WCHK:  probe_id = walk_q;
      default: probe_id = dest_q;
    endcase
    probe_in = (32'(probe_id) < NODES);
    if (probe_id == self_q) begin
      probe_hr   = 1'b1;
      probe_cost = '0;
      probe_next = self_q;
    end else if (probe_in && valid_q[probe_id[IW-1:0]]) begin
      probe_hr   = 1'b1;
      probe_cost = rd_q[MW-1:ID_W];
      probe_next = rd_q[ID_W-1:0];
    end else begin
      probe_hr   = 1'b0;
      probe_cost = '0;
      probe_next = '0;
    end
  end

  logic [COST_BITS:0]   raw_sum;
  logic                 dest_in, relax;
  logic [32:0]          in_cost_w;
  logic [COST_BITS-1:0] in_cost_sat;

  assign dest_in  = (32'(dest_q) < NODES);
  assign raw_sum  = {1'b0, probe_cost} + {1'b0, sum_q};
  assign relax    = !probe_hr || (probe_cost > sum_q);
  // input cost held at the top of the cost range
  assign in_cost_w   = 33'(cost_i);
  assign in_cost_sat = (in_cost_w > 33'(COST_MAX)) ? COST_MAX[COST_BITS-1:0]
                                                   : in_cost_w[COST_BITS-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_UPDATE)    state_d = S_RSRC;
          else if (op_i == OP_INIT) state_d = S_RDST;
          else                      state_d = S_FIN;
        end
      end
      S_RSRC: state_d = S_RDST;
      S_RDST: state_d = S_CMP;
      S_CMP: begin
        if (op_q == OP_UPDATE && dest_q != self_q && dest_in && src_ok_q && relax)
          state_d = S_WALK;
        else
          state_d = S_FIN;
      end
      S_WALK: state_d = S_WCHK;
      S_WCHK: begin
        if (!probe_hr)                         state_d = S_FIN;
        else if (probe_next == walk_q)         state_d = S_WR;
        else if (steps_q + 1'b1 == SW'(NODES)) state_d = S_FIN;
        else                                   state_d = S_WALK;
      end
      S_WR:  state_d = S_FIN;
      S_FIN: state_d = S_OUT;
      S_OUT: if (!(out_valid_o && out_stall_i)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    sum_d    = sum_q;
    src_ok_d = src_ok_q;
    walk_d   = walk_q;
    steps_d  = steps_q;
    chg_d    = chg_q;
    fail_d   = fail_q;
    send_d   = send_q;
    awake_d  = awake_q;
    msg_d    = msg_q;
    tick_d   = tick_q;
    wr_en    = 1'b0;
    wr_addr  = dest_q[IW-1:0];
    wr_data  = {sum_q, nh_q};
    nbr_set  = 1'b0;
    rd_addr  = dest_q[IW-1:0];
    case (state_q)
      S_IDLE: begin
        sum_d  = in_cost_sat;
        chg_d  = 1'b0;
        fail_d = 1'b0;
        send_d = 1'b0;
      end
      S_RSRC: rd_addr = src_q[IW-1:0];
      S_RDST: begin
        // src entry on the read port for an update
        if (op_q == OP_UPDATE) begin
          src_ok_d = probe_hr;
          sum_d    = (raw_sum > COST_MAX) ? COST_MAX[COST_BITS-1:0]
                                          : raw_sum[COST_BITS-1:0];
        end
      end
      S_CMP: begin
        if (op_q == OP_INIT) begin
          nbr_set = dest_in;
          if (dest_q != self_q && dest_in && relax) wr_en = 1'b1;
        end
        walk_d  = src_q;
        steps_d = '0;
      end
      S_WALK: rd_addr = walk_q[IW-1:0];
      S_WCHK: begin
        walk_d  = probe_next;
        steps_d = steps_q + 1'b1;
        if (!probe_hr || (probe_next != walk_q && steps_q + 1'b1 == SW'(NODES)))
          fail_d = 1'b1;
      end
      S_WR: begin
        wr_en   = 1'b1;
        wr_data = {sum_q, walk_q};
        chg_d   = 1'b1;
        msg_d   = 1'b1;
      end
      S_FIN: begin
        if (op_q == OP_UPDATE) begin
          if (last_q) begin
            if (awake_q && msg_q) begin
              send_d = 1'b1;
              tick_d = '0;
            end
            msg_d = 1'b0;
          end
        end else if (op_q == OP_WAKE) begin
          awake_d = 1'b1;
          send_d  = 1'b1;
          tick_d  = '0;
        end else if (op_q == OP_TICK && awake_q) begin
          if (tick_q + 1'b1 >= intv_q) begin
            send_d = 1'b1;
            tick_d = '0;
          end else begin
            tick_d = tick_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      nbr_q   <= '0;
      awake_q <= 1'b0;
      msg_q   <= 1'b0;
      tick_q  <= '0;
    end else begin
      state_q <= state_d;
      awake_q <= awake_d;
      msg_q   <= msg_d;
      tick_q  <= tick_d;
      if (wr_en)   valid_q[wr_addr] <= 1'b1;
      if (nbr_set) nbr_q[dest_q[IW-1:0]] <= 1'b1;
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_i;
      src_q  <= src_id_i;
      dest_q <= dest_id_i;
      nh_q   <= next_hop_i;
      last_q <= last_i;
    end
    sum_q    <= sum_d;
    src_ok_q <= src_ok_d;
    walk_q   <= walk_d;
    steps_q  <= steps_d;
    chg_q    <= chg_d;
    fail_q   <= fail_d;
    send_q   <= send_d;
  end

  // output register
  logic out_load;
  assign out_load = (state_q == S_OUT) && !(out_valid_o && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      entry_valid_o    <= probe_hr;
      entry_cost_o     <= INCOST_W'(probe_cost);
      entry_next_hop_o <= probe_next;
      is_neighbor_o    <= probe_in && nbr_q[dest_q[IW-1:0]];
      changed_o        <= chg_q;
      send_update_o    <= send_q;
      walk_failed_o    <= fail_q;
    end
  end

endmodule

// ----- rtl/dvrt_checker.sv -----
// Port-level checker for the route table, bound to the top level.
// Depends on dvrt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dvrt_checker
  import dvrt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [INCOST_W-1:0] entry_cost_o,
  input logic                entry_valid_o,
  input logic                changed_o,
  input logic                walk_failed_o
);

  // result stays offered while stalled
  `DVRT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "out dropped")
  `DVRT_ASSERT_HOLD(a_cost_hold, clk_i, rst_ni, out_valid_o && out_stall_i, entry_cost_o, "cost moved")
  // one transaction at a time
  `DVRT_ASSERT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "not busy")
  // a change always leaves a route and never coexists with a failed walk
  `DVRT_ASSERT(a_chg, clk_i, rst_ni, out_valid_o && changed_o |-> entry_valid_o && !walk_failed_o, "bad change")

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .entry_cost_o  (entry_cost_o),
  .entry_valid_o (entry_valid_o),
  .changed_o     (changed_o),
  .walk_failed_o (walk_failed_o)
);

// ----- sim/tb_distance_vector_route_table.sv -----
// Self-checking testbench for the route table: a directed table, then random
// phases under several register settings, checked against fixed expectations or a built-in predictor.
// Depends on dvrt_pkg and distance_vector_route_table.
`timescale 1ns / 1ps
module tb_distance_vector_route_table;
  import dvrt_pkg::*;

  localparam logic [OP_W-1:0] OP_READ     = 3'd4;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [15:0]     COST_TOP    = 16'hFFFF;
  localparam int              IDLE_LIMIT  = 5000;
  localparam int              SETTLE      = 200;

  typedef struct packed {
    logic            ev;
    logic [15:0]     cost;
    logic [ID_W-1:0] nh;
    logic            nb;
    logic            ch;
    logic            snd;
    logic            wf;
  } route_res_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] src;
    logic [ID_W-1:0] dest;
    logic [15:0]     cost;
    logic [ID_W-1:0] nh;
    logic            last;
  } route_item_t;

  typedef struct packed {
    route_item_t it;
    logic        typed;
    route_res_t  want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [TICK_W-1:0]     cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       op_i = '0;
  logic [ID_W-1:0]       src_id_i = '0;
  logic [ID_W-1:0]       dest_id_i = '0;
  logic [INCOST_W-1:0]   cost_i = '0;
  logic [ID_W-1:0]       next_hop_i = '0;
  logic                  last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  entry_valid_o;
  logic [INCOST_W-1:0]   entry_cost_o;
  logic [ID_W-1:0]       entry_next_hop_o;
  logic                  is_neighbor_o;
  logic                  changed_o;
  logic                  send_update_o;
  logic                  walk_failed_o;

  distance_vector_route_table u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [15:0]     tbl_cost [IDS];
  logic [ID_W-1:0] tbl_next [IDS];
  logic            tbl_valid [IDS];
  logic            tbl_nbr [IDS];
  logic            pr_awake, pr_msg_upd;
  logic [TICK_W-1:0] pr_ticks, pr_interval;
  logic [ID_W-1:0] pr_self;

  route_res_t pending_q[$];
  int n_errors, n_items, n_results, n_sends, n_changes, n_fails;
  int idle_cycles;
  logic long_hold_req = 1'b0;

  function automatic logic known(logic [ID_W-1:0] id);
    return (id == pr_self) || tbl_valid[id];
  endfunction

  function automatic logic [15:0] cost_at(logic [ID_W-1:0] id);
    if (id == pr_self || !tbl_valid[id]) return '0;
    return tbl_cost[id];
  endfunction

  function automatic logic [ID_W-1:0] next_at(logic [ID_W-1:0] id);
    if (id == pr_self) return pr_self;
    if (!tbl_valid[id]) return '0;
    return tbl_next[id];
  endfunction

  // Apply one transaction to the predictor and return what the block should report
  task automatic route_predict(input route_item_t it, output route_res_t r);
    logic [16:0]     sum;
    logic [ID_W-1:0] d, hop;
    logic            ok;
    r = '0;
    if (it.op == OP_INIT) begin
      tbl_nbr[it.dest] = 1'b1;
      if (it.dest != pr_self && (!known(it.dest) || cost_at(it.dest) > it.cost)) begin
        tbl_cost[it.dest] = it.cost;
        tbl_next[it.dest] = it.nh;
        tbl_valid[it.dest] = 1'b1;
      end
    end else if (it.op == OP_UPDATE) begin
      if (it.dest != pr_self && known(it.src)) begin
        sum = cost_at(it.src) + it.cost;
        if (sum > COST_TOP) sum = COST_TOP;
        if (!known(it.dest) || cost_at(it.dest) > sum) begin
          // chase next-hop links until an entry points at itself
          d = it.src;
          ok = 1'b0;
          hop = '0;
          for (int s = 0; s < IDS; s++) begin
            if (!known(d)) break;
            if (next_at(d) == d) begin
              hop = d;
              ok = 1'b1;
              break;
            end
            d = next_at(d);
          end
          if (ok) begin
            tbl_cost[it.dest] = sum[15:0];
            tbl_next[it.dest] = hop;
            tbl_valid[it.dest] = 1'b1;
            r.ch = 1'b1;
            pr_msg_upd = 1'b1;
          end else begin
            r.wf = 1'b1;
          end
        end
      end
      if (it.last) begin
        if (pr_awake && pr_msg_upd) begin
          r.snd = 1'b1;
          pr_ticks = '0;
        end
        pr_msg_upd = 1'b0;
      end
    end else if (it.op == OP_WAKE) begin
      pr_awake = 1'b1;
      r.snd = 1'b1;
      pr_ticks = '0;
    end else if (it.op == OP_TICK) begin
      if (pr_awake) begin
        pr_ticks = pr_ticks + 1'b1;
        if (pr_ticks >= pr_interval) begin
          r.snd = 1'b1;
          pr_ticks = '0;
        end
      end
    end
    r.ev = known(it.dest);
    r.cost = cost_at(it.dest);
    r.nh = next_at(it.dest);
    r.nb = tbl_nbr[it.dest];
  endtask

  task automatic report(input string what, input int got, input int want);
    n_errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offer one transaction and hold it until taken
  task automatic offer(input route_item_t it, input logic typed, input route_res_t want);
    route_res_t r;
    in_valid_i <= 1'b1;
    op_i <= it.op;
    src_id_i <= it.src;
    dest_id_i <= it.dest;
    cost_i <= it.cost;
    next_hop_i <= it.nh;
    last_i <= it.last;
    do @(posedge clk_i); while (in_stall_o);
    route_predict(it, r);
    pending_q.push_back(typed ? want : r);
    n_items++;
  endtask

  // Sender gap after a transaction; zero keeps valid high
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [ID_W-1:0] self_v, input logic [TICK_W-1:0] ivl);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CFG_SELF_ID;
    cfg_wdata_i <= TICK_W'(self_v);
    @(posedge clk_i);
    cfg_addr_i <= CFG_INTERVAL;
    cfg_wdata_i <= ivl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pr_self = self_v;
    pr_interval = ivl;
  endtask

  function automatic route_item_t mk(logic [OP_W-1:0] op, int src, int dest, int cost,
                                     int nh, logic last);
    route_item_t it;
    it.op = op;
    it.src = src[ID_W-1:0];
    it.dest = dest[ID_W-1:0];
    it.cost = cost[15:0];
    it.nh = nh[ID_W-1:0];
    it.last = last;
    return it;
  endfunction

  function automatic route_res_t res(logic ev, int cost, int nh, logic nb, logic ch,
                                     logic snd, logic wf);
    return '{ev, cost[15:0], nh[ID_W-1:0], nb, ch, snd, wf};
  endfunction

  function automatic stim_row_t chk(route_item_t it, route_res_t want);
    return '{it, 1'b1, want};
  endfunction

  function automatic stim_row_t pred(route_item_t it);
    return '{it, 1'b0, '0};
  endfunction

  // Random transaction, mostly on a small id pool so routes build up and get reused
  function automatic route_item_t rand_item();
    route_item_t it;
    int w;
    int pool;
    w = $urandom_range(99);
    pool = ($urandom_range(9) == 0) ? 63 : 11;
    it.src = ID_W'($urandom_range(pool));
    it.dest = ID_W'($urandom_range(pool));
    it.nh = ($urandom_range(2) == 0) ? it.dest : ID_W'($urandom_range(pool));
    it.cost = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    it.last = ($urandom_range(3) == 0);
    if (w < 25) it.op = OP_INIT;
    else if (w < 70) it.op = OP_UPDATE;
    else if (w < 73) it.op = OP_WAKE;
    else if (w < 88) it.op = OP_TICK;
    else if (w < 96) it.op = OP_READ;
    else it.op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    return it;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    route_res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_q.size() == 0) begin
        n_errors++;
        $display("[%0t] result with nothing expected", $time);
      end else begin
        w = pending_q.pop_front();
        if (entry_valid_o !== w.ev) report("entry_valid", entry_valid_o, w.ev);
        if (entry_cost_o !== w.cost) report("entry_cost", entry_cost_o, w.cost);
        if (entry_next_hop_o !== w.nh) report("entry_next_hop", entry_next_hop_o, w.nh);
        if (is_neighbor_o !== w.nb) report("is_neighbor", is_neighbor_o, w.nb);
        if (changed_o !== w.ch) report("changed", changed_o, w.ch);
        if (send_update_o !== w.snd) report("send_update", send_update_o, w.snd);
        if (walk_failed_o !== w.wf) report("walk_failed", walk_failed_o, w.wf);
        n_sends += w.snd;
        n_changes += w.ch;
        n_fails += w.wf;
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off on request
  initial begin
    int mode, span;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      mode = $urandom_range(2);
      span = $urandom_range(200, 40);
      for (int c = 0; c < span; c++) begin
        if (mode == 0) out_stall_i <= 1'b0;
        else if (mode == 1) out_stall_i <= ($urandom_range(1) == 0);
        else out_stall_i <= (c % 7 < 3);
        @(posedge clk_i);
      end
    end
  end

  // Watchdog on transactions in either direction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb_distance_vector_route_table NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_q[$];
    logic [ID_W-1:0] selves[5];
    logic [TICK_W-1:0] ivls[5];
    int burst;
    for (int i = 0; i < IDS; i++) begin
      tbl_cost[i] = '0;
      tbl_next[i] = '0;
      tbl_valid[i] = 1'b0;
      tbl_nbr[i] = 1'b0;
    end
    pr_awake = 1'b0;
    pr_msg_upd = 1'b0;
    pr_ticks = '0;
    pr_self = '0;
    pr_interval = TICK_W'(100);
    n_errors = 0;
    n_items = 0;
    n_results = 0;
    n_sends = 0;
    n_changes = 0;
    n_fails = 0;
    idle_cycles = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset settings (self 0, interval 100)
    dir_q.push_back(chk(mk(OP_READ, 0, 5, 0, 0, 0), res(0, 0, 0, 0, 0, 0, 0)));
    dir_q.push_back(chk(mk(OP_READ, 0, 0, 0, 0, 0), res(1, 0, 0, 0, 0, 0, 0)));
    dir_q.push_back(chk(mk(OP_INIT, 0, 1, 10, 1, 0), res(1, 10, 1, 1, 0, 0, 0)));
    dir_q.push_back(chk(mk(OP_INIT, 0, 2, 65535, 2, 0), res(1, 65535, 2, 1, 0, 0, 0)));
    dir_q.push_back(chk(mk(OP_INIT, 0, 0, 5, 3, 0), res(1, 0, 0, 1, 0, 0, 0)));
    dir_q.push_back(chk(mk(OP_INIT, 0, 63, 0, 63, 0), res(1, 0, 63, 1, 0, 0, 0)));
    dir_q.push_back(pred(mk(OP_UPDATE, 1, 3, 5, 0, 0)));
    dir_q.push_back(pred(mk(OP_UPDATE, 2, 4, 65535, 0, 0)));
    dir_q.push_back(chk(mk(OP_UPDATE, 7, 5, 1, 0, 0), res(0, 0, 0, 0, 0, 0, 0)));
    dir_q.push_back(chk(mk(OP_INIT, 0, 9, 3, 8, 0), res(1, 3, 8, 1, 0, 0, 0)));
    dir_q.push_back(chk(mk(OP_UPDATE, 9, 10, 1, 0, 0), res(0, 0, 0, 0, 0, 0, 1)));
    dir_q.push_back(pred(mk(OP_INIT, 0, 20, 2, 21, 0)));
    dir_q.push_back(pred(mk(OP_INIT, 0, 21, 2, 20, 0)));
    dir_q.push_back(chk(mk(OP_UPDATE, 20, 22, 1, 0, 0), res(0, 0, 0, 0, 0, 0, 1)));
    dir_q.push_back(pred(mk(OP_UPDATE, 0, 11, 4, 0, 1)));
    dir_q.push_back(pred(mk(OP_WAKE, 0, 1, 0, 0, 0)));
    dir_q.push_back(pred(mk(OP_UPDATE, 1, 12, 1, 0, 1)));
    dir_q.push_back(pred(mk(OP_UPDATE, 1, 12, 9, 0, 1)));
    dir_q.push_back(pred(mk(OP_UPDATE, 1, 0, 1, 0, 0)));
    dir_q.push_back(pred(mk(OP_TICK, 0, 3, 0, 0, 0)));
    dir_q.push_back(pred(mk(OP_TICK, 0, 3, 0, 0, 0)));
    dir_q.push_back(pred(mk(OP_SPARE_LO, 0, 1, 0, 0, 0)));
    dir_q.push_back(pred(mk(OP_SPARE_HI, 63, 63, 65535, 63, 1)));
    foreach (dir_q[i]) begin
      offer(dir_q[i].it, dir_q[i].typed, dir_q[i].want);
      pause_sender($urandom_range(1) ? 0 : $urandom_range(3));
    end
    drain();

    // Random phases over several settings, extremes included
    selves = '{6'd63, 6'd0, 6'd37, 6'd5, 6'd0};
    ivls = '{20'd1, 20'd0, 20'd1000000, 20'd3, 20'hFFFFF};
    for (int p = 0; p < 5; p++) begin
      write_regs(selves[p], ivls[p]);
      burst = 0;
      for (int k = 0; k < 180; k++) begin
        if (p == 1 && k == 60) long_hold_req = 1'b1;
        if (p == 3 && k == 90) begin
          in_valid_i <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk_i);
        end
        offer(rand_item(), 1'b0, '0);
        if (burst == 0) begin
          burst = $urandom_range(12, 1);
          pause_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1));
        end else begin
          burst--;
        end
      end
      drain();
    end

    $display("%0d transactions in, %0d results out over 6 register settings", n_items, n_results);
    $display("%0d table changes, %0d send requests, %0d failed walks", n_changes, n_sends,
             n_fails);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("tb_distance_vector_route_table OK");
    end else begin
      $display("tb_distance_vector_route_table NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dvrt_pkg.sv
rtl/distance_vector_route_table.sv
rtl/dvrt_checker.sv
sim/tb_distance_vector_route_table.sv
